### src/ktsu_pkg.sv
// ----------------------------------------------------------------------------
// ktsu_pkg
// Shared constants, codes and types for the keyed priority task store.
// ----------------------------------------------------------------------------
`default_nettype none
package ktsu_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CHANGE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_EXEC   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    WR_SET   = 2'd0,
    WR_PRIO  = 2'd1,
    WR_CLEAR = 2'd2,
    WR_NONE  = 2'd3
  } wr_op_t;

  typedef struct packed {
    logic             active;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
    logic             top_ok;
    logic [31:0]      top_prio;
    logic [15:0]      top_task;
    logic [15:0]      top_owner;
    logic [IDX_W-1:0] top_idx;
  } scan_t;

  typedef struct packed {
    logic             en;
    wr_op_t           op;
    logic [IDX_W-1:0] idx;
    logic [15:0]      tsk;
    logic [15:0]      owner;
    logic [31:0]      prio;
  } wr_t;

endpackage
`default_nettype wire

### src/ktsu_cell.sv
// ----------------------------------------------------------------------------
// ktsu_cell
// One store entry plus one stage of the search record that walks the chain.
// ----------------------------------------------------------------------------
`default_nettype none
module ktsu_cell import ktsu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [15:0]      key,
  input  scan_t            scan_in,
  output scan_t            scan_out,
  input  wr_t              wr
);

  logic        valid;
  logic [15:0] tsk;
  logic [15:0] owner;
  logic [31:0] prio;
  scan_t       scan_next;
  logic        sel;

  assign sel = wr.en && (wr.idx == cell_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      unique case (wr.op)
        WR_SET:   valid <= 1'b1;
        WR_CLEAR: valid <= 1'b0;
        default:  valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.op == WR_SET) begin
      tsk   <= wr.tsk;
      owner <= wr.owner;
    end
    if (sel && (wr.op == WR_SET || wr.op == WR_PRIO)) begin
      prio <= wr.prio;
    end
  end

  always_comb begin
    scan_next = scan_in;
    if (valid && tsk == key) begin
      scan_next.hit     = 1'b1;
      scan_next.hit_idx = cell_idx;
    end
    if (!valid && !scan_in.free_ok) begin
      scan_next.free_ok  = 1'b1;
      scan_next.free_idx = cell_idx;
    end
    if (valid && (!scan_in.top_ok || prio > scan_in.top_prio ||
                  (prio == scan_in.top_prio && tsk > scan_in.top_task))) begin
      scan_next.top_ok    = 1'b1;
      scan_next.top_prio  = prio;
      scan_next.top_task  = tsk;
      scan_next.top_owner = owner;
      scan_next.top_idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
    end
  end

endmodule
`default_nettype wire

### src/keyed_priority_task_store_unit.sv
// ----------------------------------------------------------------------------
// keyed_priority_task_store_unit
// Store of tasks with add, change priority, remove and execute-top commands.
// ----------------------------------------------------------------------------
// The input channel carries one command beat (command, task_id, owner_id,
// prio); the output channel returns one beat (status, served_owner) for each.
// A search record enters the first cell of a chain of CAPACITY cells and
// moves one cell per cycle, collecting the matching entry, the lowest free
// entry and the top entry. When it leaves the last cell the store is updated
// and the result is formed. After acceptance the command passes the launch,
// scan and drain states before its result beat is offered; the block takes one
// command at a time, so the chain length sets the command rate.
// The next command may be accepted while a result still waits on the output
// register; its own result is held until the receiver takes the earlier one.
// Reset empties the store and drops any command in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_priority_task_store_unit import ktsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] task_id,
  input  logic [15:0] owner_id,
  input  logic [31:0] prio,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] served_owner
);

  typedef enum logic [1:0] {S_IDLE, S_LAUNCH, S_SCAN, S_DRAIN} state_t;

  state_t      state;
  cmd_t        cmd_q;
  logic [15:0] task_q;
  logic [15:0] owner_q;
  logic [31:0] prio_q;
  status_t     pend_status;
  logic [15:0] pend_served;
  status_t     fin_status;
  logic [15:0] fin_served;
  scan_t       links [CAPACITY+1];
  scan_t       last;
  wr_t         wr;

  assign in_ready = (state == S_IDLE);
  assign last     = links[CAPACITY];

  always_comb begin
    links[0]        = '0;
    links[0].active = (state == S_LAUNCH);
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      ktsu_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_idx (IDX_W'(g)),
        .key      (task_q),
        .scan_in  (links[g]),
        .scan_out (links[g+1]),
        .wr       (wr)
      );
    end
  endgenerate

  always_comb begin
    wr.en      = 1'b0;
    wr.op      = WR_NONE;
    wr.idx     = last.hit_idx;
    wr.tsk     = task_q;
    wr.owner   = owner_q;
    wr.prio    = prio_q;
    fin_status = ST_OK;
    fin_served = 16'd0;
    unique case (cmd_q)
      CMD_ADD: begin
        if (last.hit) begin
          wr.op = WR_SET;
        end else if (last.free_ok) begin
          wr.op  = WR_SET;
          wr.idx = last.free_idx;
        end else begin
          fin_status = ST_FULL;
        end
      end
      CMD_CHANGE: begin
        if (last.hit) wr.op = WR_PRIO;
        else fin_status = ST_NOT_FOUND;
      end
      CMD_REMOVE: begin
        if (last.hit) wr.op = WR_CLEAR;
        else fin_status = ST_NOT_FOUND;
      end
      CMD_EXEC: begin
        if (last.top_ok) begin
          wr.op      = WR_CLEAR;
          wr.idx     = last.top_idx;
          fin_served = last.top_owner;
        end else begin
          fin_status = ST_EMPTY;
        end
      end
      default: fin_status = ST_OK;
    endcase
    wr.en = (state == S_SCAN) && last.active && (wr.op != WR_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cmd_q     <= CMD_EXEC;
    end else begin
      if (out_valid && out_ready && state != S_DRAIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q   <= cmd_t'(command);
            task_q  <= task_id;
            owner_q <= owner_id;
            prio_q  <= prio;
            state   <= S_LAUNCH;
          end
        end
        S_LAUNCH: state <= S_SCAN;
        S_SCAN: begin
          if (last.active) begin
            pend_status <= fin_status;
            pend_served <= fin_served;
            state       <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= pend_status;
            served_owner <= pend_served;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// Testbench for keyed_priority_task_store_unit
// A directed table of commands and a fill past capacity come before random
// command streams. Every result beat is compared with a software copy of the
// task store kept here. Sender and receiver idle at random, then not at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import ktsu_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_ADD;
  logic [15:0] task_id = '0;
  logic [15:0] owner_id = '0;
  logic [31:0] prio = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] served_owner;

  keyed_priority_task_store_unit DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .task_id(task_id), .owner_id(owner_id), .prio(prio),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .served_owner(served_owner)
  );

  always #4 clk = ~clk;

  typedef struct {
    status_t     st;
    logic [15:0] owner;
  } reply_t;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] id;
    logic [15:0] own;
    logic [31:0] pr;
    logic        fixed;
    status_t     st;
    logic [15:0] owner;
  } row_t;

  logic        st_valid [CAPACITY];
  logic [15:0] st_task  [CAPACITY];
  logic [15:0] st_owner [CAPACITY];
  logic [31:0] st_prio  [CAPACITY];

  reply_t      pending_replies[$];
  reply_t      typed_replies[$];
  logic        typed_flags[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle = 22;
  int          recv_idle = 45;
  bit          hold_recv = 1'b0;
  logic [15:0] known_ids[$];

  function automatic reply_t apply_command(cmd_t c, logic [15:0] id, logic [15:0] own,
                                           logic [31:0] pr);
    reply_t r;
    int     hit;
    int     best;
    r.st = ST_OK;
    r.owner = '0;
    hit = -1;
    best = -1;
    for (int i = 0; i < CAPACITY; i++)
      if (st_valid[i] && st_task[i] == id && hit < 0) hit = i;
    case (c)
      CMD_ADD: begin
        if (hit < 0)
          for (int i = 0; i < CAPACITY; i++)
            if (!st_valid[i] && hit < 0) hit = i;
        if (hit < 0) begin
          r.st = ST_FULL;
        end else begin
          st_valid[hit] = 1'b1;
          st_task[hit] = id;
          st_owner[hit] = own;
          st_prio[hit] = pr;
        end
      end
      CMD_CHANGE: begin
        if (hit < 0) r.st = ST_NOT_FOUND;
        else st_prio[hit] = pr;
      end
      CMD_REMOVE: begin
        if (hit < 0) r.st = ST_NOT_FOUND;
        else st_valid[hit] = 1'b0;
      end
      default: begin
        for (int i = 0; i < CAPACITY; i++)
          if (st_valid[i] && (best < 0 || st_prio[i] > st_prio[best] ||
              (st_prio[i] == st_prio[best] && st_task[i] > st_task[best])))
            best = i;
        if (best < 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.owner = st_owner[best];
          st_valid[best] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_command(cmd_t c, logic [15:0] id, logic [15:0] own, logic [31:0] pr,
                              logic fixed = 1'b0, status_t st = ST_OK,
                              logic [15:0] owner = '0);
    reply_t r;
    reply_t t;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    task_id <= id;
    owner_id <= own;
    prio <= pr;
    do @(posedge clk); while (!in_ready);
    r = apply_command(c, id, own, pr);
    pending_replies.push_back(r);
    t.st = st;
    t.owner = owner;
    typed_replies.push_back(t);
    typed_flags.push_back(fixed);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst || hold_recv) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    reply_t exp_r;
    reply_t typed;
    logic   fixed;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: status %0d", status);
      end else begin
        exp_r = pending_replies.pop_front();
        typed = typed_replies.pop_front();
        fixed = typed_flags.pop_front();
        if (fixed && (typed.st != exp_r.st || typed.owner != exp_r.owner)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Table row disagrees with predictor: %0d/%0d vs %0d/%0d",
                     typed.st, typed.owner, exp_r.st, exp_r.owner);
        end
        if (status != exp_r.st || served_owner != exp_r.owner) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: status exp %0d got %0d, owner exp %0h got %0h",
                     exp_r.st, status, exp_r.owner, served_owner);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_prio();
    case ($urandom_range(3))
      0: return $urandom_range(3);
      1: return 32'hFFFF_FFFF - $urandom_range(1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_id();
    if (known_ids.size() != 0 && $urandom_range(3) != 0)
      return known_ids[$urandom_range(known_ids.size() - 1)];
    return ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(40));
  endfunction

  task automatic random_block(int n);
    cmd_t        c;
    logic [15:0] id;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: c = CMD_ADD;
        4: c = CMD_CHANGE;
        5: c = CMD_REMOVE;
        default: c = CMD_EXEC;
      endcase
      id = rand_id();
      if (c == CMD_ADD) known_ids.push_back(id);
      if (known_ids.size() > 100) void'(known_ids.pop_front());
      send_command(c, id, 16'($urandom), rand_prio());
    end
  endtask

  row_t table_rows[] = '{
    '{CMD_EXEC,   16'h0000, 16'h0000, 32'h0,          1'b1, ST_EMPTY,     16'h0},
    '{CMD_CHANGE, 16'h0005, 16'h0000, 32'h1,          1'b1, ST_NOT_FOUND, 16'h0},
    '{CMD_REMOVE, 16'hFFFF, 16'h0000, 32'h0,          1'b1, ST_NOT_FOUND, 16'h0},
    '{CMD_ADD,    16'h0000, 16'h1111, 32'h0,          1'b1, ST_OK,        16'h0},
    '{CMD_ADD,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,  1'b1, ST_OK,        16'h0},
    '{CMD_ADD,    16'h0010, 16'h2222, 32'hFFFF_FFFF,  1'b1, ST_OK,        16'h0},
    '{CMD_EXEC,   16'h0000, 16'h0000, 32'h0,          1'b1, ST_OK,        16'hFFFF},
    '{CMD_EXEC,   16'h0000, 16'h0000, 32'h0,          1'b1, ST_OK,        16'h2222},
    '{CMD_ADD,    16'h0000, 16'hABCD, 32'h7,          1'b1, ST_OK,        16'h0},
    '{CMD_ADD,    16'h0020, 16'h0001, 32'h3,          1'b1, ST_OK,        16'h0},
    '{CMD_CHANGE, 16'h0020, 16'h0000, 32'h9,          1'b1, ST_OK,        16'h0},
    '{CMD_EXEC,   16'h0000, 16'h0000, 32'h0,          1'b1, ST_OK,        16'h0001},
    '{CMD_REMOVE, 16'h0000, 16'h0000, 32'h0,          1'b1, ST_OK,        16'h0},
    '{CMD_EXEC,   16'h0000, 16'h0000, 32'h0,          1'b1, ST_EMPTY,     16'h0},
    '{CMD_ADD,    16'h5555, 16'hAAAA, 32'hAAAA_5555,  1'b0, ST_OK,        16'h0},
    '{CMD_ADD,    16'hAAAA, 16'h5555, 32'h5555_AAAA,  1'b0, ST_OK,        16'h0},
    '{CMD_REMOVE, 16'h5555, 16'h0000, 32'h0,          1'b0, ST_OK,        16'h0},
    '{CMD_ADD,    16'h5555, 16'h0F0F, 32'h5555_AAAA,  1'b0, ST_OK,        16'h0},
    '{CMD_EXEC,   16'h0000, 16'h0000, 32'h0,          1'b0, ST_OK,        16'h0},
    '{CMD_EXEC,   16'h0000, 16'h0000, 32'h0,          1'b0, ST_OK,        16'h0}
  };

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      st_valid[i] = 1'b0;
      st_task[i] = '0;
      st_owner[i] = '0;
      st_prio[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_rows[i])
      send_command(table_rows[i].cmd, table_rows[i].id, table_rows[i].own, table_rows[i].pr,
                   table_rows[i].fixed, table_rows[i].st, table_rows[i].owner);
    wait_drained();

    // Fill past capacity, then add an already stored id while full.
    for (int i = 0; i < CAPACITY + 2; i++)
      send_command(CMD_ADD, 16'(100 + i), 16'($urandom), 32'($urandom_range(5)));
    send_command(CMD_ADD, 16'd100, 16'h7777, 32'hFFFF_FFFF);
    send_command(CMD_EXEC, '0, '0, '0, 1'b1, ST_OK, 16'h7777);

    random_block(300);
    hold_recv = 1'b1;
    fork
      random_block(8);
      begin
        repeat (600) @(negedge clk);
        hold_recv = 1'b0;
      end
    join
    wait_drained();
    send_idle = 45;
    recv_idle = 22;
    random_block(350);
    send_idle = 0;
    recv_idle = 0;
    random_block(350);
    for (int i = 0; i < CAPACITY + 1; i++) send_command(CMD_EXEC, '0, '0, '0);

    wait_drained();
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
